FILE: hdl/ngh_pkg.sv
package ngh_pkg;

  // Default datapath sizes
  localparam int SAMPLE_WIDTH_DEF    = 24;
  localparam int COEFF_FRAC_BITS_DEF = 16;

  // Fixed register field widths
  localparam int COEFF_W    = 16;
  localparam int THR_W      = 24;
  localparam int HOLD_W     = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENV_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENV_RELEASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_RISE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FALL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_LEN    = 3'd5;

  // Register reset values
  localparam logic [COEFF_W-1:0] ENV_ATTACK_RST  = 16'd62000;
  localparam logic [COEFF_W-1:0] ENV_RELEASE_RST = 16'd65500;
  localparam logic [COEFF_W-1:0] GAIN_RISE_RST   = 16'd65000;
  localparam logic [COEFF_W-1:0] GAIN_FALL_RST   = 16'd65500;
  localparam logic [THR_W-1:0]   THRESHOLD_RST   = 24'd83886;
  localparam logic [HOLD_W-1:0]  HOLD_LEN_RST    = 20'd2400;

  // Gate phase codes, as seen on the gate_phase port
  typedef enum logic [1:0] {
    PH_CLOSED  = 2'd0,
    PH_ATTACK  = 2'd1,
    PH_HOLD    = 2'd2,
    PH_RELEASE = 2'd3
  } gate_phase_t;

endpackage

FILE: hdl/ngh_mul.sv
// Shared unsigned multiplier with a registered product
module ngh_mul #(
  parameter int A_W = 24,
  parameter int B_W = 17
) (
  input  logic               clk,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
  end

endmodule

FILE: hdl/noise_gate_with_hold.sv
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    sample_in
// output    out        out_valid / out_ready  sample_out, gain_now, gate_phase
// config    in         cfg_we (no wait)       cfg_index, cfg_data
//
// Each sample passes through an accept step and six sequencer steps, during
// which the single shared multiplier runs three times (envelope pole, gain
// ramp, output product), each product registered before use.
// in_ready is high only while the sequencer is idle; a finished result waits
// in the output register and a stalled output holds the last step.
// Synchronous reset loads the register defaults and clears envelope, gain,
// gate phase and hold count.
module noise_gate_with_hold
  import ngh_pkg::*;
#(
  parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
  parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out,
  output logic [COEFF_FRAC_BITS:0]      gain_now,
  output logic [1:0]                    gate_phase,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int W    = SAMPLE_WIDTH;
  localparam int F    = COEFF_FRAC_BITS;
  localparam int GW   = F + 1;
  localparam int AW   = (W > GW) ? W : GW;
  localparam int PW   = AW + GW;
  localparam int RW   = PW - F;
  localparam int CMPW = (W > THR_W) ? W : THR_W;

  localparam longint unsigned ONE_L = 64'd1 << F;
  localparam logic [GW-1:0] ONE       = GW'(ONE_L);
  localparam logic [GW-1:0] OPEN_MARK = GW'((ONE_L * 999 + 999) / 1000);
  localparam logic [GW-1:0] SHUT_MARK = GW'(ONE_L / 1000);
  localparam logic [RW-1:0] POS_MAX   = RW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [RW-1:0] NEG_MAX   = RW'(64'd1 << (W - 1));

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENV_MUL,
    S_GATE,
    S_GAIN_MUL,
    S_GAIN_UPD,
    S_OUT_MUL,
    S_DONE
  } seq_t;

  // Coefficient as a Q0.F fraction, saturated below one
  function automatic logic [F-1:0] clamp_coeff(input logic [COEFF_W-1:0] c);
    logic [31:0] cw;
    cw = 32'(c);
    if (cw >= 32'(ONE_L)) return '1;
    return F'(cw);
  endfunction

  // Configuration registers
  logic [COEFF_W-1:0] env_attack_coeff, env_release_coeff;
  logic [COEFF_W-1:0] gain_rise_coeff, gain_fall_coeff;
  logic [THR_W-1:0]   open_threshold;
  logic [HOLD_W-1:0]  hold_length;

  // Gate state and per-sample working registers
  seq_t               seq;
  logic [W-1:0]       envelope_level;
  logic [GW-1:0]      gate_gain;
  gate_phase_t        gate_st;
  logic [HOLD_W-1:0]  hold_count;
  logic [W-1:0]       mag;
  logic               neg;
  logic               env_ge;
  logic               gain_ge;
  logic [GW-1:0]      target;

  // Shared multiplier operands and product
  logic [AW-1:0] mul_a;
  logic [GW-1:0] mul_b;
  logic [PW-1:0] prod;

  ngh_mul #(.A_W(AW), .B_W(GW)) u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .p  (prod)
  );

  // Operand selection per sequencer step
  logic [W-1:0]  env_diff;
  logic [GW-1:0] gain_tgt;
  logic          gain_ge_c;
  logic [GW-1:0] gain_diff;
  logic          env_ge_c;

  always_comb begin
    env_ge_c  = envelope_level >= mag;
    env_diff  = env_ge_c ? (envelope_level - mag) : (mag - envelope_level);
    gain_tgt  = (gate_st == PH_ATTACK || gate_st == PH_HOLD) ? ONE : '0;
    gain_ge_c = gate_gain >= gain_tgt;
    gain_diff = gain_ge_c ? (gate_gain - gain_tgt) : (gain_tgt - gate_gain);
    mul_a = '0;
    mul_b = '0;
    unique case (seq)
      S_ENV_MUL: begin
        mul_a = AW'(env_diff);
        mul_b = GW'(clamp_coeff(env_ge_c ? env_release_coeff : env_attack_coeff));
      end
      S_GAIN_MUL: begin
        mul_a = AW'(gain_diff);
        mul_b = GW'(clamp_coeff(gain_ge_c ? gain_fall_coeff : gain_rise_coeff));
      end
      // output product stays in place while the result waits
      S_OUT_MUL, S_DONE: begin
        mul_a = AW'(mag);
        mul_b = gate_gain;
      end
      default: begin
      end
    endcase
  end

  // Envelope update and gate decision from the envelope product
  logic [W-1:0]      env_step;
  logic [W-1:0]      env_new;
  logic              loud;
  gate_phase_t       st_next;
  logic [GW-1:0]     gain_snap;
  logic [HOLD_W-1:0] hold_next;

  always_comb begin
    env_step  = prod[F +: W];
    env_new   = env_ge ? (mag + env_step) : (mag - env_step);
    loud      = CMPW'(env_new) >= CMPW'(open_threshold);
    st_next   = gate_st;
    gain_snap = gate_gain;
    hold_next = hold_count;
    unique case (gate_st)
      PH_CLOSED: begin
        if (loud) st_next = PH_ATTACK;
      end
      PH_ATTACK: begin
        if (gate_gain >= OPEN_MARK) begin
          gain_snap = ONE;
          hold_next = hold_length;
          st_next   = PH_HOLD;
        end
        if (!loud) st_next = PH_RELEASE;
      end
      PH_HOLD: begin
        if (hold_count <= HOLD_W'(1)) begin
          if (loud) begin
            hold_next = hold_length;
          end else begin
            hold_next = '0;
            st_next   = PH_RELEASE;
          end
        end else begin
          hold_next = hold_count - HOLD_W'(1);
        end
      end
      PH_RELEASE: begin
        if (loud) begin
          st_next = PH_ATTACK;
        end else if (gate_gain <= SHUT_MARK) begin
          gain_snap = '0;
          st_next   = PH_CLOSED;
        end
      end
      default: begin
      end
    endcase
  end

  // Gain ramp result and output saturation
  logic [GW-1:0] gain_step;
  logic [GW-1:0] gain_new;
  logic [RW-1:0] out_mag;
  logic [W-1:0]  out_clip;
  logic [W-1:0]  out_word;

  always_comb begin
    gain_step = prod[F +: GW];
    gain_new  = gain_ge ? (target + gain_step) : (target - gain_step);
    out_mag   = prod[PW-1:F];
    if (neg) out_clip = (out_mag > NEG_MAX) ? W'(NEG_MAX) : W'(out_mag);
    else     out_clip = (out_mag > POS_MAX) ? W'(POS_MAX) : W'(out_mag);
    out_word  = neg ? (W'(0) - out_clip) : out_clip;
  end

  assign in_ready = (seq == S_IDLE);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      env_attack_coeff  <= ENV_ATTACK_RST;
      env_release_coeff <= ENV_RELEASE_RST;
      gain_rise_coeff   <= GAIN_RISE_RST;
      gain_fall_coeff   <= GAIN_FALL_RST;
      open_threshold    <= THRESHOLD_RST;
      hold_length       <= HOLD_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENV_ATTACK:  env_attack_coeff  <= cfg_data[COEFF_W-1:0];
        REG_ENV_RELEASE: env_release_coeff <= cfg_data[COEFF_W-1:0];
        REG_GAIN_RISE:   gain_rise_coeff   <= cfg_data[COEFF_W-1:0];
        REG_GAIN_FALL:   gain_fall_coeff   <= cfg_data[COEFF_W-1:0];
        REG_THRESHOLD:   open_threshold    <= cfg_data[THR_W-1:0];
        REG_HOLD_LEN:    hold_length       <= cfg_data[HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer, gate state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      seq            <= S_IDLE;
      envelope_level <= '0;
      gate_gain      <= '0;
      gate_st        <= PH_CLOSED;
      hold_count     <= '0;
      out_valid      <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself
      if (out_valid && out_ready && (seq != S_DONE)) out_valid <= 1'b0;
      unique case (seq)
        S_IDLE: begin
          if (in_valid) begin
            neg <= sample_in[W-1];
            mag <= sample_in[W-1] ? (W'(0) - W'(sample_in)) : W'(sample_in);
            seq <= S_ENV_MUL;
          end
        end
        S_ENV_MUL: begin
          env_ge <= env_ge_c;
          seq    <= S_GATE;
        end
        S_GATE: begin
          envelope_level <= env_new;
          gate_st        <= st_next;
          gate_gain      <= gain_snap;
          hold_count     <= hold_next;
          seq            <= S_GAIN_MUL;
        end
        S_GAIN_MUL: begin
          target  <= gain_tgt;
          gain_ge <= gain_ge_c;
          seq     <= S_GAIN_UPD;
        end
        S_GAIN_UPD: begin
          gate_gain <= gain_new;
          seq       <= S_OUT_MUL;
        end
        S_OUT_MUL: begin
          seq <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            sample_out <= out_word;
            gain_now   <= gate_gain;
            gate_phase <= gate_st;
            out_valid  <= 1'b1;
            seq        <= S_IDLE;
          end
        end
        default: seq <= S_IDLE;
      endcase
    end
  end

  // Gain never exceeds unity
  a_gain_range: assert property (@(posedge clk) disable iff (rst) gate_gain <= ONE)
    else $error("gate gain above unity");

  // Hold phase keeps full gain
  a_hold_unity: assert property (@(posedge clk) disable iff (rst)
    gate_st == PH_HOLD |-> gate_gain == ONE)
    else $error("hold phase without full gain");

  // Closed phase keeps zero gain
  a_closed_zero: assert property (@(posedge clk) disable iff (rst)
    gate_st == PH_CLOSED |-> gate_gain == '0)
    else $error("closed phase with nonzero gain");

  // An accepted transaction starts the envelope multiply
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> seq == S_ENV_MUL)
    else $error("accepted sample did not start the sequencer");

endmodule
